>>> design/pso_pkg.sv
// Shared constants and types for the point-to-segment offset vector block.
// No dependencies; used by pso_div and point_segment_offset_vector.
package pso_pkg;

    // Default coordinate width (two's complement, Q16.16 by default).
    localparam int COORD_BITS_DEF  = 32;
    // Default number of fractional bits of the segment parameter t.
    localparam int T_FRAC_BITS_DEF = 16;

    // How the segment parameter t is chosen for one item.
    typedef enum logic [1:0] {
        T_SEL_ZERO = 2'd0,
        T_SEL_ONE  = 2'd1,
        T_SEL_DIV  = 2'd2
    } t_sel_t;

    // Pipeline flow control between the top level and the divider.
    typedef struct packed {
        logic en;
        logic valid;
    } pso_flow_t;

endpackage

>>> design/point_segment_offset_vector.sv
// Top level of the point-to-segment offset vector pipeline.
// Depends on pso_pkg and pso_div.

// For a query point P and a segment S..E this block returns the vector from P
// to the nearest point of the segment, t*(E-S) - (P-S), with t = (P-S).(E-S) /
// |E-S|^2 clamped to [0,1] and truncated to T_FRAC_BITS fractional bits. Each
// component saturates to COORD_BITS and sets saturated; a zero-length segment
// gives S-P with degenerate_segment set. The block accepts one item per clock
// while the output is not stalled; the divider, which resolves one quotient
// bit per stage, makes up most of the pipeline.
// A stall at the output freezes the whole pipeline, and in_stall follows it.
module point_segment_offset_vector #(
    parameter int COORD_BITS  = pso_pkg::COORD_BITS_DEF,
    parameter int T_FRAC_BITS = pso_pkg::T_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] start_z,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] end_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] offset_x,
    output logic signed [COORD_BITS-1:0] offset_y,
    output logic signed [COORD_BITS-1:0] offset_z,
    output logic                         degenerate_segment,
    output logic                         saturated
);
    import pso_pkg::*;

    localparam int DW     = COORD_BITS + 1;        // difference width
    localparam int PW     = 2 * DW;                // product width
    localparam int SW     = PW + 2;                // sum of three products
    localparam int TW     = T_FRAC_BITS + 1;       // t including the 1.0 value
    localparam int MW     = TW + 1 + DW;           // t times difference
    localparam int RW     = DW + 2;                // result before saturation
    localparam int SIDE_W = 1 + 2 + 6 * DW;

    localparam logic signed [RW-1:0] SAT_HI =
        {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO =
        {{(RW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

    logic      en;
    pso_flow_t div_flow;

    // Whole-pipeline advance: hold everything while the result is not taken.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic signed [COORD_BITS-1:0] pt [3];
    logic signed [COORD_BITS-1:0] st [3];
    logic signed [COORD_BITS-1:0] ep [3];

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;
    assign st[0] = start_x;
    assign st[1] = start_y;
    assign st[2] = start_z;
    assign ep[0] = end_x;
    assign ep[1] = end_y;
    assign ep[2] = end_z;

    // Stage 1: direction d = E - S and offset w = P - S.
    logic                 v1_reg;
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] w1_reg [3];

    // Stage 2: per-axis products d*d and w*d.
    logic                 v2_reg;
    logic signed [PW-1:0] dd2_reg [3];
    logic signed [PW-1:0] wd2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [DW-1:0] w2_reg [3];

    // Stage 3: squared length and dot product.
    logic                 v3_reg;
    logic signed [SW-1:0] len3_reg;
    logic signed [SW-1:0] dot3_reg;
    logic signed [DW-1:0] d3_reg [3];
    logic signed [DW-1:0] w3_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= DW'(ep[i]) - DW'(st[i]);
                w1_reg[i]  <= DW'(pt[i]) - DW'(st[i]);
                dd2_reg[i] <= d1_reg[i] * d1_reg[i];
                wd2_reg[i] <= w1_reg[i] * d1_reg[i];
                d2_reg[i]  <= d1_reg[i];
                w2_reg[i]  <= w1_reg[i];
                d3_reg[i]  <= d2_reg[i];
                w3_reg[i]  <= w2_reg[i];
            end
            len3_reg <= SW'(dd2_reg[0]) + SW'(dd2_reg[1]) + SW'(dd2_reg[2]);
            dot3_reg <= SW'(wd2_reg[0]) + SW'(wd2_reg[1]) + SW'(wd2_reg[2]);
        end
    end

    // Classify the item: clamp cases skip the division result.
    logic             degen3;
    t_sel_t           tsel3;
    logic [SW-1:0]    dividend3;
    logic [SIDE_W-1:0] side3;

    always_comb
    begin
        degen3 = (len3_reg == '0);
        priority if (dot3_reg[SW-1] || dot3_reg == '0)
            tsel3 = T_SEL_ZERO;
        else if (dot3_reg >= len3_reg)
            tsel3 = T_SEL_ONE;
        else
            tsel3 = T_SEL_DIV;
        dividend3 = (tsel3 == T_SEL_DIV && !degen3) ? dot3_reg : '0;
        side3 = {degen3, tsel3,
                 d3_reg[0], d3_reg[1], d3_reg[2],
                 w3_reg[0], w3_reg[1], w3_reg[2]};
    end

    assign div_flow.en    = en;
    assign div_flow.valid = v3_reg;

    logic                   vq;
    logic [T_FRAC_BITS-1:0] quo;
    logic [SIDE_W-1:0]      sideq;

    pso_div #(
        .NUM_W  (SW),
        .Q_BITS (T_FRAC_BITS),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .flow     (div_flow),
        .dividend (dividend3),
        .divisor  (len3_reg),
        .side     (side3),
        .q_valid  (vq),
        .quotient (quo),
        .q_side   (sideq)
    );

    // Unpack the sideband and pick t.
    logic                 degen_q;
    t_sel_t               tsel_q;
    logic signed [DW-1:0] dq [3];
    logic signed [DW-1:0] wq [3];
    logic [TW-1:0]        t_q;

    always_comb
    begin
        degen_q = sideq[SIDE_W-1];
        tsel_q  = t_sel_t'(sideq[SIDE_W-2 -: 2]);
        for (int i = 0; i < 3; i++)
        begin
            dq[i] = sideq[(6-i)*DW-1 -: DW];
            wq[i] = sideq[(3-i)*DW-1 -: DW];
        end
        unique case (tsel_q)
            T_SEL_ZERO: t_q = '0;
            T_SEL_ONE:  t_q = {1'b1, {T_FRAC_BITS{1'b0}}};
            T_SEL_DIV:  t_q = {1'b0, quo};
            default:    t_q = '0;
        endcase
    end

    // Stage M: t*d per axis; a degenerate segment has d = 0, so this is zero.
    logic                 vm_reg;
    logic                 degen_m_reg;
    logic signed [MW-1:0] pm_reg [3];
    logic signed [DW-1:0] wm_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= vq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_m_reg <= degen_q;
            for (int i = 0; i < 3; i++)
            begin
                pm_reg[i] <= $signed({1'b0, t_q}) * dq[i];
                wm_reg[i] <= wq[i];
            end
        end
    end

    // Output stage: floor shift, subtract w, saturate.
    logic signed [MW-1:0]         shifted [3];
    logic signed [RW-1:0]         diff    [3];
    logic signed [COORD_BITS-1:0] res     [3];
    logic [2:0]                   clip;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = pm_reg[i] >>> T_FRAC_BITS;
            diff[i]    = RW'(shifted[i]) - RW'(wm_reg[i]);
            priority if (diff[i] > SAT_HI)
            begin
                res[i]  = SAT_HI[COORD_BITS-1:0];
                clip[i] = 1'b1;
            end
            else if (diff[i] < SAT_LO)
            begin
                res[i]  = SAT_LO[COORD_BITS-1:0];
                clip[i] = 1'b1;
            end
            else
            begin
                res[i]  = diff[i][COORD_BITS-1:0];
                clip[i] = 1'b0;
            end
        end
    end

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] off_reg [3];
    logic                         degen_reg;
    logic                         sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i] <= res[i];
            end
            degen_reg <= degen_m_reg;
            sat_reg   <= |clip;
        end
    end

    assign out_valid          = out_valid_reg;
    assign offset_x           = off_reg[0];
    assign offset_y           = off_reg[1];
    assign offset_z           = off_reg[2];
    assign degenerate_segment = degen_reg;
    assign saturated          = sat_reg;

`ifndef NO_ASSERTIONS
    // The input side stalls only while a finished result is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // A saturated result has at least one component at a range limit.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (offset_x == SAT_HI[COORD_BITS-1:0] || offset_x == SAT_LO[COORD_BITS-1:0] ||
             offset_y == SAT_HI[COORD_BITS-1:0] || offset_y == SAT_LO[COORD_BITS-1:0] ||
             offset_z == SAT_HI[COORD_BITS-1:0] || offset_z == SAT_LO[COORD_BITS-1:0]))
        else $error("saturated flag without a clipped component");

    // A held result stays valid, with offset_x and saturated unchanged, while the pipeline is frozen.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(offset_x) && $stable(saturated)))
        else $error("held result changed");
`endif

endmodule

>>> design/pso_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on pso_pkg; carries a sideband word alongside the quotient.
module pso_div #(
    parameter int NUM_W  = 68,
    parameter int Q_BITS = 16,
    parameter int SIDE_W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pso_pkg::pso_flow_t     flow,
    input  logic [NUM_W-1:0]       dividend,
    input  logic [NUM_W-1:0]       divisor,
    input  logic [SIDE_W-1:0]      side,
    output logic                   q_valid,
    output logic [Q_BITS-1:0]      quotient,
    output logic [SIDE_W-1:0]      q_side
);
    import pso_pkg::*;

    localparam int RW = NUM_W + 1;

    logic              valid_reg [0:Q_BITS];
    logic [RW-1:0]     rem_reg   [0:Q_BITS];
    logic [NUM_W-1:0]  dvs_reg   [0:Q_BITS];
    logic [Q_BITS-1:0] quo_reg   [0:Q_BITS];
    logic [SIDE_W-1:0] side_reg  [0:Q_BITS];

    // Entry stage: load the partial remainder with the dividend.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (flow.en)
        begin
            valid_reg[0] <= flow.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.en)
        begin
            rem_reg[0]  <= {1'b0, dividend};
            dvs_reg[0]  <= divisor;
            quo_reg[0]  <= '0;
            side_reg[0] <= side;
        end
    end

    // Each stage doubles the remainder and subtracts the divisor if it fits.
    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_stage
        logic [RW-1:0] rem_shift;
        logic [RW-1:0] dvs_ext;
        logic          fits;

        assign rem_shift = {rem_reg[k][RW-2:0], 1'b0};
        assign dvs_ext   = {1'b0, dvs_reg[k]};
        assign fits      = (rem_shift >= dvs_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (flow.en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (flow.en)
            begin
                rem_reg[k+1]  <= fits ? (rem_shift - dvs_ext) : rem_shift;
                dvs_reg[k+1]  <= dvs_reg[k];
                quo_reg[k+1]  <= {quo_reg[k][Q_BITS-2:0], fits};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign q_valid  = valid_reg[Q_BITS];
    assign quotient = quo_reg[Q_BITS];
    assign q_side   = side_reg[Q_BITS];

endmodule
